// ----- rtl/core/keyed_counter_table_windowed_macros.svh -----
// assertion macros used by the checker of the counter table
`ifndef KEYED_COUNTER_TABLE_WINDOWED_MACROS_SVH
`define KEYED_COUNTER_TABLE_WINDOWED_MACROS_SVH

// checked only out of reset
`define KCTW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define KCTW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/kctw_pkg.sv -----
package kctw_pkg;

    // operation codes
    localparam logic OP_INC = 1'b0;
    localparam logic OP_QRY = 1'b1;

    // input beat
    typedef struct packed {
        logic               op;
        logic [31:0]        server_addr;
        logic signed [31:0] amount;
        logic [62:0]        now;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic signed [63:0] count;
        logic               was_present;
        logic               status;
    } out_beat_t;

    // request token walking down the cell chain
    typedef struct packed {
        logic               vld;
        logic               op;
        logic [31:0]        key;
        logic signed [31:0] amount;
        logic               found;
        logic               free_ok;
        logic [63:0]        count;
    } tok_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        clr;
        logic        ins;
        logic [31:0] ins_key;
    } ctl_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WALK,
        ST_DRAIN
    } state_t;

endpackage

// ----- rtl/core/kctw_cell.sv -----
module kctw_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kctw_pkg::ctl_t      ctl,
    input  logic [IDX_W-1:0]    ins_idx,
    input  kctw_pkg::tok_t      tok_in,
    input  logic [IDX_W-1:0]    free_in,
    output kctw_pkg::tok_t      tok_out,
    output logic [IDX_W-1:0]    free_out
);

    logic [31:0]        key_reg;
    logic [63:0]        count_reg;
    logic               valid_reg;
    logic               valid_next;
    kctw_pkg::tok_t     tok_reg;
    kctw_pkg::tok_t     tok_next;
    logic [IDX_W-1:0]   free_reg;
    logic [IDX_W-1:0]   free_next;
    logic               valid_eff;
    logic               hit;
    logic               ins_here;
    logic [63:0]        sum;

    // a clear in this cycle already hides the entry from the token
    assign valid_eff = valid_reg & ~ctl.clr;
    assign hit       = tok_in.vld & valid_eff & (key_reg == tok_in.key);
    assign ins_here  = ctl.ins & (ins_idx == IDX_W'(IDX));
    assign sum       = count_reg + {{32{tok_in.amount[31]}}, tok_in.amount};

    // token update at this cell
    always_comb begin
        tok_next  = tok_in;
        free_next = free_in;
        if (hit) begin
            tok_next.found = 1'b1;
            tok_next.count = (tok_in.op == kctw_pkg::OP_INC) ? sum : count_reg;
        end
        if (tok_in.vld && !tok_in.free_ok && !valid_eff) begin
            tok_next.free_ok = 1'b1;
            free_next        = IDX_W'(IDX);
        end
    end

    // valid bit
    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ins_here) begin
            valid_next = 1'b1;
        end
    end

    // valid bit and token, reset clears the valid bit and only the token valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            tok_reg     <= tok_next;
        end
    end

    // entry payload and free slot index
    always_ff @(posedge aclk) begin
        if (ins_here) begin
            key_reg   <= ctl.ins_key;
            count_reg <= '0;
        end else if (hit && tok_in.op == kctw_pkg::OP_INC) begin
            count_reg <= sum;
        end
        free_reg        <= free_next;
    end

    assign tok_out  = tok_reg;
    assign free_out = free_reg;

endmodule

// ----- rtl/core/keyed_counter_table_windowed.sv -----
// channel  | direction | beat type              | handshake
// s_       | in        | kctw_pkg::in_beat_t    | s_valid / s_ready
// m_       | out       | kctw_pkg::out_beat_t   | m_valid / m_ready
// cfg_     | in        | 63-bit clear interval  | cfg_wr_en, no wait
//
// one beat passes accept, launch, the request token walking the chain through the
// token register of each cell, the result register, then the output register.
// the walk through the row of cells dominates a beat; one item is in flight.
// reset (aresetn low, synchronous) invalidates all entries, clears the last
// clear time and the interval; keys and counts are not cleared.
// a stalled result is held in the output register while the next beat is taken.
module keyed_counter_table_windowed #(
    parameter int ENTRIES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kctw_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kctw_pkg::out_beat_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [62:0]          cfg_wr_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    kctw_pkg::state_t     state_reg;
    kctw_pkg::state_t     state_next;
    kctw_pkg::in_beat_t   item_reg;
    kctw_pkg::out_beat_t  res_reg;
    kctw_pkg::out_beat_t  res_next;
    kctw_pkg::out_beat_t  m_data_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [62:0]          interval_reg;
    logic [62:0]          last_clear_reg;
    logic [62:0]          last_clear_next;
    logic [62:0]          elapsed;
    logic                 clr;
    logic                 out_free;
    kctw_pkg::ctl_t       ctl;
    kctw_pkg::tok_t       tok_w  [ENTRIES+1];
    logic [IDX_W-1:0]     free_w [ENTRIES+1];
    kctw_pkg::tok_t       last_tok;

    assign last_tok = tok_w[ENTRIES];
    assign out_free = ~m_valid_reg | m_ready;

    // window check on increments
    assign elapsed = item_reg.now - last_clear_reg;
    assign clr = (state_reg == kctw_pkg::ST_LAUNCH) && (item_reg.op == kctw_pkg::OP_INC)
                 && (interval_reg != '0) && (item_reg.now > last_clear_reg)
                 && (elapsed > interval_reg);

    // token entering the first cell
    assign tok_w[0] = '{vld:     (state_reg == kctw_pkg::ST_LAUNCH),
                        op:      item_reg.op,
                        key:     item_reg.server_addr,
                        amount:  item_reg.amount,
                        found:   1'b0,
                        free_ok: 1'b0,
                        count:   64'd0};
    assign free_w[0] = '0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kctw_pkg::ST_IDLE: begin
                if (s_valid) state_next = kctw_pkg::ST_LAUNCH;
            end
            kctw_pkg::ST_LAUNCH: begin
                state_next = kctw_pkg::ST_WALK;
            end
            kctw_pkg::ST_WALK: begin
                if (last_tok.vld) state_next = kctw_pkg::ST_DRAIN;
            end
            kctw_pkg::ST_DRAIN: begin
                if (out_free) state_next = kctw_pkg::ST_IDLE;
            end
            default: state_next = kctw_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready     = (state_reg == kctw_pkg::ST_IDLE);
        ctl.clr     = clr;
        ctl.ins     = (state_reg == kctw_pkg::ST_WALK) && last_tok.vld
                      && (last_tok.op == kctw_pkg::OP_INC) && !last_tok.found
                      && last_tok.free_ok;
        ctl.ins_key = last_tok.key;

        last_clear_next = clr ? item_reg.now : last_clear_reg;

        res_next = res_reg;
        if ((state_reg == kctw_pkg::ST_WALK) && last_tok.vld) begin
            res_next.count       = last_tok.found ? last_tok.count : '0;
            res_next.was_present = last_tok.found;
            res_next.status      = (last_tok.op == kctw_pkg::OP_INC) && !last_tok.found
                                   && !last_tok.free_ok;
        end

        m_valid_next = m_valid_reg;
        if ((state_reg == kctw_pkg::ST_DRAIN) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kctw_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            interval_reg   <= '0;
            last_clear_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            last_clear_reg <= last_clear_next;
            if (cfg_wr_en) interval_reg <= cfg_wr_data;
        end
    end

    // beat payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) item_reg <= s_data;
        res_reg <= res_next;
        if ((state_reg == kctw_pkg::ST_DRAIN) && out_free) m_data_reg <= res_reg;
    end

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        kctw_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .ins_idx  (free_w[ENTRIES]),
            .tok_in   (tok_w[i]),
            .free_in  (free_w[i]),
            .tok_out  (tok_w[i+1]),
            .free_out (free_w[i+1])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/kctw_checker.sv -----
`include "keyed_counter_table_windowed_macros.svh"

module kctw_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input kctw_pkg::in_beat_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input kctw_pkg::out_beat_t  m_data
);

    // no result beat right after reset
    `KCTW_ASSERT_ALWAYS(a_rst_quiet, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result stays offered
    `KCTW_ASSERT_RST(a_m_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // one item in flight: no beat taken right after an accepted one
    `KCTW_ASSERT_RST(a_one_item, s_valid && s_ready |=> !s_ready,
        "input ready right after accept")

    // a dropped insert reports nothing found and a zero count
    `KCTW_ASSERT_RST(a_full_result,
        m_valid && m_data.status |-> !m_data.was_present && (m_data.count == 64'sd0),
        "full status with present key or nonzero count")

    // an absent key always reads as zero
    `KCTW_ASSERT_RST(a_absent_zero,
        m_valid && !m_data.was_present |-> (m_data.count == 64'sd0),
        "absent key with nonzero count")

endmodule

bind keyed_counter_table_windowed kctw_checker u_kctw_checker (.*);
